// File: rtl/nzda_pkg.sv
// Shared types, constants and helpers for the ZDA date/time sentence parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package nzda_pkg;

   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int INDEX_W  = 3;
   localparam int YEAR_W   = 14;
   localparam int PAIR_W   = 7;

   localparam int TIME_LEN  = 6;
   localparam int DAY_LEN   = 2;
   localparam int MONTH_LEN = 2;
   localparam int YEAR_LEN  = 4;
   localparam int TAG_LEN   = 4;

   localparam logic [INDEX_W-1:0] DAY_BASE   = 3'd0;
   localparam logic [INDEX_W-1:0] MONTH_BASE = 3'd2;
   localparam logic [INDEX_W-1:0] YEAR_BASE  = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_D     = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

   typedef enum logic [2:0] {
      PH_TAG   = 3'd0,
      PH_TIME  = 3'd1,
      PH_DAY   = 3'd2,
      PH_MONTH = 3'd3,
      PH_YEAR  = 3'd4,
      PH_EMIT  = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [TIME_LEN-1:0][DIGIT_W-1:0] time_digits_type;
   typedef logic [DAY_LEN+MONTH_LEN+YEAR_LEN-1:0][DIGIT_W-1:0] date_digits_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [PAIR_W-1:0] month;
      logic [PAIR_W-1:0] day;
      logic [PAIR_W-1:0] hour;
      logic [PAIR_W-1:0] minute;
      logic [PAIR_W-1:0] second;
   } result_type;

   function automatic logic [CHAR_W-1:0] tag_char(input logic [1:0] pos);
      case (pos)
         2'd0:    return CHAR_Z;
         2'd1:    return CHAR_D;
         2'd2:    return CHAR_A;
         default: return CHAR_COMMA;
      endcase
   endfunction

   // Low nibble of the character, clamped to nine.
   function automatic digit_type to_digit(input logic [CHAR_W-1:0] c);
      return (c[3:0] > 4'd9) ? 4'd9 : c[3:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/nzda_if.sv
// Valid/ready channel interfaces: character input and date/time result.
// Depends on nzda_pkg for field widths.
`default_nettype none

interface nzda_req_if;
   import nzda_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] rx_char;
   modport source (output valid, output rx_char, input ready);
   modport sink   (input valid, input rx_char, output ready);
endinterface

interface nzda_rsp_if;
   import nzda_pkg::*;
   logic              valid;
   logic              ready;
   logic [YEAR_W-1:0] year;
   logic [PAIR_W-1:0] month;
   logic [PAIR_W-1:0] day;
   logic [PAIR_W-1:0] hour;
   logic [PAIR_W-1:0] minute;
   logic [PAIR_W-1:0] second;
   modport source (output valid, output year, output month, output day,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day,
                   input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

// File: rtl/nmea_zda_datetime_parser_unit.sv
// ZDA sentence parser: one character per item, one date/time result per sentence.
// A result is valid the cycle after the character that follows the year comma.
// Throughput: one character per cycle while ready is high; ready drops while a result is
// held and not taken, and the next character is let in as the held result leaves.
// Reset (synchronous, active high) returns to tag search and clears all digit slots.
// Depends on nzda_pkg, nzda_if and nzda_convert.
`default_nettype none

module nmea_zda_datetime_parser_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   nzda_req_if.sink    req_chan,
   nzda_rsp_if.source  rsp_chan
);
   import nzda_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   time_digits_type       time_ff, time_in;
   date_digits_type       date_ff, date_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff, out_in;
   result_type            conv;
   logic                  in_accept;
   logic                  emit;
   logic [CHAR_W-1:0]     c;
   logic [INDEX_W-1:0]    index_inc;

   nzda_convert u_convert (
      .time_digits (time_ff),
      .date_digits (date_ff),
      .result      (conv)
   );

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign in_accept      = req_chan.valid && req_chan.ready;
   assign c              = req_chan.rx_char;
   assign index_inc      = INDEX_W'(index_ff + 3'd1);

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      time_in  = time_ff;
      date_in  = date_ff;
      emit     = 1'b0;
      if (in_accept) begin
         case (phase_ff)
            PH_TAG: begin
               if (tag_char(index_ff[1:0]) == c) begin
                  if (index_inc >= INDEX_W'(TAG_LEN)) begin
                     phase_in = PH_TIME;
                     index_in = '0;
                  end else begin
                     index_in = index_inc;
                  end
               end else begin
                  index_in = '0;
               end
            end
            PH_TIME, PH_DAY, PH_MONTH, PH_YEAR: begin
               if (c == CHAR_COMMA) begin
                  phase_in = phase_type'(3'(phase_ff + 3'd1));
                  index_in = '0;
               end else if (phase_ff == PH_TIME) begin
                  if (index_ff < INDEX_W'(TIME_LEN)) begin
                     time_in[index_ff] = to_digit(c);
                     index_in          = index_inc;
                  end
               end else if (phase_ff == PH_DAY) begin
                  if (index_ff < INDEX_W'(DAY_LEN)) begin
                     date_in[INDEX_W'(DAY_BASE + index_ff)] = to_digit(c);
                     index_in                               = index_inc;
                  end
               end else if (phase_ff == PH_MONTH) begin
                  if (index_ff < INDEX_W'(MONTH_LEN)) begin
                     date_in[INDEX_W'(MONTH_BASE + index_ff)] = to_digit(c);
                     index_in                                 = index_inc;
                  end
               end else begin
                  if (index_ff < INDEX_W'(YEAR_LEN)) begin
                     date_in[INDEX_W'(YEAR_BASE + index_ff)] = to_digit(c);
                     index_in                                = index_inc;
                  end
               end
            end
            PH_EMIT: begin
               phase_in = PH_DONE;
               index_in = '0;
               emit     = 1'b1;
            end
            default: begin
               // done phase and the unused code: drop the item, restart tag search
               phase_in = PH_TAG;
               index_in = '0;
            end
         endcase
      end
   end

   // Hold a waiting result until taken; a new one may load as the old one leaves.
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in       = conv;
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         index_ff     <= '0;
         time_ff      <= '0;
         date_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         time_ff      <= time_in;
         date_ff      <= date_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.year   = out_ff.year;
   assign rsp_chan.month  = out_ff.month;
   assign rsp_chan.day    = out_ff.day;
   assign rsp_chan.hour   = out_ff.hour;
   assign rsp_chan.minute = out_ff.minute;
   assign rsp_chan.second = out_ff.second;

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_accept && phase_ff == PH_EMIT))
      else $error("result appeared without an emit-phase item");

   a_emit_next: assert property (@(posedge clock) disable iff (reset)
      (in_accept && phase_ff == PH_EMIT) |=> (phase_ff == PH_DONE && rsp_chan.valid))
      else $error("emit-phase item did not yield a result");

   a_tag_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TAG) |-> (index_ff < INDEX_W'(TAG_LEN)))
      else $error("tag match position out of range");

   a_time_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TIME) |-> (index_ff <= INDEX_W'(TIME_LEN)))
      else $error("time field position out of range");

endmodule

`default_nettype wire

// File: rtl/nzda_convert.sv
// Decimal conversion of the captured digit slots into binary date/time values.
// Depends on nzda_pkg.
`default_nettype none

module nzda_convert (
   input  wire nzda_pkg::time_digits_type time_digits,
   input  wire nzda_pkg::date_digits_type date_digits,
   output nzda_pkg::result_type           result
);
   import nzda_pkg::*;

   function automatic logic [PAIR_W-1:0] pair(input digit_type hi, input digit_type lo);
      return PAIR_W'(hi) * PAIR_W'(10) + PAIR_W'(lo);
   endfunction

   always_comb begin
      result.year   = YEAR_W'(date_digits[4]) * YEAR_W'(1000)
                    + YEAR_W'(date_digits[5]) * YEAR_W'(100)
                    + YEAR_W'(date_digits[6]) * YEAR_W'(10)
                    + YEAR_W'(date_digits[7]);
      result.month  = pair(date_digits[2], date_digits[3]);
      result.day    = pair(date_digits[0], date_digits[1]);
      result.hour   = pair(time_digits[0], time_digits[1]);
      result.minute = pair(time_digits[2], time_digits[3]);
      result.second = pair(time_digits[4], time_digits[5]);
   end

endmodule

`default_nettype wire
